>>> hw/rtl/mfvn_pkg.sv
// Shared constants and types for the mesh face and vertex normal block.
// No dependencies; imported by every module of the block.
package mfvn_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 14;
  localparam int SUM_BITS   = 23;
  localparam int OUT_BITS   = 16;
  localparam int VEC_BITS   = 36;   // signed vector component into the normaliser
  localparam int MUL_BITS   = 32;   // shared multiplier operand width
  localparam int PROD_BITS  = 64;

  typedef logic signed [VEC_BITS-1:0] vec_t;
  typedef logic signed [OUT_BITS-1:0] nrm_t;

  typedef struct packed {
    logic signed [MUL_BITS-1:0] a;
    logic signed [MUL_BITS-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic zero;
  } norm_stat_t;

endpackage

>>> hw/rtl/mfvn_mul.sv
// Shared signed multiplier with a registered product.
// Depends on mfvn_pkg.
module mfvn_mul (
  input  logic                                  clk,
  input  mfvn_pkg::mul_req_t                    req,
  output logic signed [mfvn_pkg::PROD_BITS-1:0] prod_r
);
  import mfvn_pkg::*;

  always_ff @(posedge clk) begin
    prod_r <= PROD_BITS'(req.a * req.b);
  end

endmodule

>>> hw/rtl/mfvn_norm.sv
// Vector normaliser: block shift, sum of squares on the shared multiplier,
// bit-serial square root and restoring division. Depends on mfvn_pkg.
module mfvn_norm (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  input  mfvn_pkg::vec_t                        vx,
  input  mfvn_pkg::vec_t                        vy,
  input  mfvn_pkg::vec_t                        vz,
  output mfvn_pkg::mul_req_t                    mreq,
  input  logic signed [mfvn_pkg::PROD_BITS-1:0] prod,
  output mfvn_pkg::norm_stat_t                  stat,
  output mfvn_pkg::nrm_t                        qx,
  output mfvn_pkg::nrm_t                        qy,
  output mfvn_pkg::nrm_t                        qz
);
  import mfvn_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_SHIFT, S_SQ, S_SQRT, S_DIV} st_t;

  st_t         state_r;
  logic [34:0] m_r [3];
  logic        neg_r [3];
  logic [63:0] s_r;
  logic [63:0] res_r;
  logic [4:0]  k_r;
  logic [1:0]  cnt_r;
  logic [1:0]  ci_r;
  logic [3:0]  j_r;
  logic [31:0] rem_r;
  logic [14:0] low_r;
  logic [14:0] q_r;
  nrm_t        q_r_out [3];
  logic        done_r;
  logic        zero_r;

  logic [34:0] top;
  logic [63:0] sq_bit;
  logic [63:0] sq_trial;
  logic [31:0] rt;
  logic [29:0] m_sel;
  logic [44:0] num;
  logic [32:0] rem2;
  logic        qbit;
  logic [14:0] q_nxt;
  logic [34:0] sq_op;

  assign top      = m_r[0] | m_r[1] | m_r[2];
  assign sq_bit   = 64'(1) << {k_r, 1'b0};
  assign sq_trial = res_r + sq_bit;
  assign rt       = res_r[31:0];
  assign m_sel    = m_r[ci_r][29:0];
  assign num      = {1'b0, m_sel, {FRAC_BITS{1'b0}}} + 45'(rt >> 1);
  assign rem2     = {rem_r, low_r[14]};
  assign qbit     = (rem2 >= {1'b0, rt});
  assign q_nxt    = {q_r[13:0], qbit};

  always_comb begin
    case (cnt_r)
      2'd0:    sq_op = m_r[0];
      2'd1:    sq_op = m_r[1];
      2'd2:    sq_op = m_r[2];
      default: sq_op = '0;
    endcase
  end

  assign mreq.a = {2'b00, sq_op[29:0]};
  assign mreq.b = {2'b00, sq_op[29:0]};

  assign stat.busy = (state_r != S_IDLE);
  assign stat.done = done_r;
  assign stat.zero = zero_r;
  assign qx = q_r_out[0];
  assign qy = q_r_out[1];
  assign qz = q_r_out[2];

  always_ff @(posedge clk) begin
    done_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      zero_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (start) begin
            m_r[0]  <= vx[VEC_BITS-1] ? 35'(-vx) : vx[34:0];
            m_r[1]  <= vy[VEC_BITS-1] ? 35'(-vy) : vy[34:0];
            m_r[2]  <= vz[VEC_BITS-1] ? 35'(-vz) : vz[34:0];
            neg_r[0] <= vx[VEC_BITS-1];
            neg_r[1] <= vy[VEC_BITS-1];
            neg_r[2] <= vz[VEC_BITS-1];
            state_r <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (top == '0) begin
            // zero vector: zero result, flag it
            for (int i = 0; i < 3; i++) q_r_out[i] <= '0;
            zero_r  <= 1'b1;
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else if (top[34:30] != '0) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] >> 1;
          end else if (!top[29]) begin
            for (int i = 0; i < 3; i++) m_r[i] <= m_r[i] << 1;
          end else begin
            cnt_r   <= '0;
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          if (cnt_r == 2'd0) s_r <= '0;
          else               s_r <= s_r + 64'(prod);
          if (cnt_r == 2'd3) begin
            res_r   <= '0;
            k_r     <= 5'd31;
            state_r <= S_SQRT;
          end
          cnt_r <= cnt_r + 2'd1;
        end
        S_SQRT: begin
          if (s_r >= sq_trial) begin
            s_r   <= s_r - sq_trial;
            res_r <= (res_r >> 1) + sq_bit;
          end else begin
            res_r <= res_r >> 1;
          end
          if (k_r == '0) begin
            ci_r    <= '0;
            j_r     <= '0;
            state_r <= S_DIV;
          end
          k_r <= k_r - 5'd1;
        end
        S_DIV: begin
          if (j_r == '0) begin
            rem_r <= 32'(num[44:15]);
            low_r <= num[14:0];
            q_r   <= '0;
          end else begin
            if (qbit) rem_r <= 32'(rem2 - {1'b0, rt});
            else      rem_r <= rem2[31:0];
            low_r <= low_r << 1;
            q_r   <= q_nxt;
            if (j_r == 4'd15) begin
              q_r_out[ci_r] <= neg_r[ci_r] ? -OUT_BITS'(q_nxt) : OUT_BITS'(q_nxt);
              if (ci_r == 2'd2) begin
                zero_r  <= 1'b0;
                done_r  <= 1'b1;
                state_r <= S_IDLE;
              end
              ci_r <= ci_r + 2'd1;
            end
          end
          j_r <= j_r + 4'd1;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/mesh_face_and_vertex_normals_top.sv
// Mesh face and vertex normals: cross product, face normal, vertex accumulation.
// Words are taken one at a time: the next face word is taken once the result of the last
// is out. Each normalisation: block shift, the sum of squares on the shared multiplier,
// the bit-serial square root and a restoring division for each component.
// Reset (rst_n low, synchronous): idle, sums cleared; uses mfvn_pkg, mfvn_mul, mfvn_norm.
module mesh_face_and_vertex_normals_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_corner0_x,
  input  logic signed [15:0] in_corner0_y,
  input  logic signed [15:0] in_corner0_z,
  input  logic signed [15:0] in_corner1_x,
  input  logic signed [15:0] in_corner1_y,
  input  logic signed [15:0] in_corner1_z,
  input  logic signed [15:0] in_corner2_x,
  input  logic signed [15:0] in_corner2_y,
  input  logic signed [15:0] in_corner2_z,
  input  logic        in_last_face,
  input  logic        in_vertex_unused,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] out_face_nx,
  output logic signed [15:0] out_face_ny,
  output logic signed [15:0] out_face_nz,
  output logic        out_face_degenerate,
  output logic signed [15:0] out_vertex_nx,
  output logic signed [15:0] out_vertex_ny,
  output logic signed [15:0] out_vertex_nz,
  output logic        out_vertex_done
);
  import mfvn_pkg::*;

  typedef enum logic [2:0] {T_IDLE, T_CROSS, T_FACE, T_VERT, T_FIN} st_t;

  st_t state_r;

  // edge vectors p1-p0 and p2-p0
  logic signed [COORD_BITS:0] a_r [3];
  logic signed [COORD_BITS:0] b_r [3];
  logic signed [VEC_BITS-1:0] c_r [3];
  logic signed [VEC_BITS-1:0] part_r;
  logic [2:0] cnt_r;
  logic       last_r;

  logic signed [SUM_BITS-1:0] sum_r [3];

  // result words held until taken
  nrm_t fn_r [3];
  nrm_t vn_r [3];
  logic deg_r;
  logic done_r;
  logic out_valid_r;
  nrm_t ofn_r [3];
  nrm_t ovn_r [3];
  logic odeg_r;
  logic odone_r;

  // normaliser hookup
  logic       nstart_r;
  vec_t       nv_r [3];
  norm_stat_t nstat;
  mul_req_t   nreq;
  mul_req_t   creq;
  mul_req_t   mreq;
  logic signed [PROD_BITS-1:0] prod;
  nrm_t       qx, qy, qz;

  logic signed [SUM_BITS:0] sadd [3];
  logic signed [SUM_BITS-1:0] snew [3];
  nrm_t qv [3];
  logic in_acc;

  assign qv[0] = qx;
  assign qv[1] = qy;
  assign qv[2] = qz;

  assign in_ready = (state_r == T_IDLE);
  assign in_acc   = in_valid && in_ready;

  // pick the cross-product operand pair for this step
  always_comb begin
    creq = '0;
    case (cnt_r)
      3'd0: begin creq.a = MUL_BITS'(a_r[1]); creq.b = MUL_BITS'(b_r[2]); end
      3'd1: begin creq.a = MUL_BITS'(a_r[2]); creq.b = MUL_BITS'(b_r[1]); end
      3'd2: begin creq.a = MUL_BITS'(a_r[2]); creq.b = MUL_BITS'(b_r[0]); end
      3'd3: begin creq.a = MUL_BITS'(a_r[0]); creq.b = MUL_BITS'(b_r[2]); end
      3'd4: begin creq.a = MUL_BITS'(a_r[0]); creq.b = MUL_BITS'(b_r[1]); end
      3'd5: begin creq.a = MUL_BITS'(a_r[1]); creq.b = MUL_BITS'(b_r[0]); end
      default: creq = '0;
    endcase
  end

  assign mreq = (state_r == T_CROSS) ? creq : nreq;

  mfvn_mul u_mul (
    .clk    (clk),
    .req    (mreq),
    .prod_r (prod)
  );

  mfvn_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (nstart_r),
    .vx    (nv_r[0]),
    .vy    (nv_r[1]),
    .vz    (nv_r[2]),
    .mreq  (nreq),
    .prod  (prod),
    .stat  (nstat),
    .qx    (qx),
    .qy    (qy),
    .qz    (qz)
  );

  // saturating accumulate of the fresh face normal
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sadd[i] = {sum_r[i][SUM_BITS-1], sum_r[i]} + (SUM_BITS+1)'(qv[i]);
      if (sadd[i] > (SUM_BITS+1)'(2**(SUM_BITS-1) - 1))
        snew[i] = {1'b0, {(SUM_BITS-1){1'b1}}};
      else if (sadd[i] < -(SUM_BITS+1)'(2**(SUM_BITS-1)))
        snew[i] = {1'b1, {(SUM_BITS-1){1'b0}}};
      else
        snew[i] = sadd[i][SUM_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    nstart_r <= 1'b0;
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        T_IDLE: begin
          if (in_acc) begin
            last_r <= in_last_face;
            if (in_vertex_unused) begin
              // no faces: clear sums, report a finished zero vertex
              for (int i = 0; i < 3; i++) begin
                sum_r[i] <= '0;
                fn_r[i]  <= '0;
                vn_r[i]  <= '0;
              end
              deg_r   <= 1'b0;
              done_r  <= 1'b1;
              state_r <= T_FIN;
            end else begin
              a_r[0] <= 17'(in_corner1_x) - 17'(in_corner0_x);
              a_r[1] <= 17'(in_corner1_y) - 17'(in_corner0_y);
              a_r[2] <= 17'(in_corner1_z) - 17'(in_corner0_z);
              b_r[0] <= 17'(in_corner2_x) - 17'(in_corner0_x);
              b_r[1] <= 17'(in_corner2_y) - 17'(in_corner0_y);
              b_r[2] <= 17'(in_corner2_z) - 17'(in_corner0_z);
              cnt_r   <= '0;
              state_r <= T_CROSS;
            end
          end
        end
        T_CROSS: begin
          // product of the previous step lands now
          case (cnt_r)
            3'd1:    part_r <= VEC_BITS'(prod);
            3'd2:    c_r[0] <= part_r - VEC_BITS'(prod);
            3'd3:    part_r <= VEC_BITS'(prod);
            3'd4:    c_r[1] <= part_r - VEC_BITS'(prod);
            3'd5:    part_r <= VEC_BITS'(prod);
            3'd6: begin
              nv_r[0]  <= c_r[0];
              nv_r[1]  <= c_r[1];
              nv_r[2]  <= part_r - VEC_BITS'(prod);
              nstart_r <= 1'b1;
              state_r  <= T_FACE;
            end
            default: ;
          endcase
          cnt_r <= cnt_r + 3'd1;
        end
        T_FACE: begin
          if (nstat.done) begin
            for (int i = 0; i < 3; i++) begin
              fn_r[i] <= qv[i];
              vn_r[i] <= '0;
            end
            deg_r <= nstat.zero;
            if (last_r) begin
              for (int i = 0; i < 3; i++) begin
                nv_r[i]  <= VEC_BITS'(snew[i]);
                sum_r[i] <= '0;
              end
              nstart_r <= 1'b1;
              state_r  <= T_VERT;
            end else begin
              for (int i = 0; i < 3; i++) sum_r[i] <= snew[i];
              done_r  <= 1'b0;
              state_r <= T_FIN;
            end
          end
        end
        T_VERT: begin
          if (nstat.done) begin
            for (int i = 0; i < 3; i++) vn_r[i] <= qv[i];
            done_r  <= 1'b1;
            state_r <= T_FIN;
          end
        end
        T_FIN: begin
          // hand over once the output register is free
          if (!out_valid_r || out_ready) begin
            for (int i = 0; i < 3; i++) begin
              ofn_r[i] <= fn_r[i];
              ovn_r[i] <= vn_r[i];
            end
            odeg_r      <= deg_r;
            odone_r     <= done_r;
            out_valid_r <= 1'b1;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_face_nx         = ofn_r[0];
  assign out_face_ny         = ofn_r[1];
  assign out_face_nz         = ofn_r[2];
  assign out_face_degenerate = odeg_r;
  assign out_vertex_nx       = ovn_r[0];
  assign out_vertex_ny       = ovn_r[1];
  assign out_vertex_nz       = ovn_r[2];
  assign out_vertex_done     = odone_r;

`ifndef SYNTHESIS
  a_vert_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_vertex_done) |->
      (out_vertex_nx == 0 && out_vertex_ny == 0 && out_vertex_nz == 0))
    else $error("vertex normal set without vertex_done");
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_face_degenerate) |->
      (out_face_nx == 0 && out_face_ny == 0 && out_face_nz == 0))
    else $error("degenerate face with nonzero normal");
  a_norm_owner: assert property (@(posedge clk) disable iff (!rst_n)
    nstat.done |-> (state_r == T_FACE || state_r == T_VERT))
    else $error("normaliser finished with no caller");
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second word taken while busy");
`endif

endmodule
